// ===== hdl/ssnf_pkg.sv =====
// Shared constants, types and segment lookup for the seven-segment frame unit.
package ssnf_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_W = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W = 5;
    localparam int VAL_W = 32;

    localparam logic [IDX_W-1:0] CLEAR_LAST_IDX = IDX_W'(18);
    localparam logic [IDX_W-1:0] SHOW_LAST_IDX = IDX_W'(2 * NUM_DIGITS);

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_SHOW = 1'b1;

    localparam logic [7:0] BYTE_AUTO_INC = 8'h40;
    localparam logic [7:0] BYTE_ADDR0 = 8'hc0;
    localparam logic [7:0] BYTE_DISP_ON = 8'h88;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [63:0] RECIP10 = 64'h0000_0000_cccc_cccd;
    localparam int RECIP10_SHIFT = 35;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ssnf_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic is_clear;
        logic emit_last;
        logic out_free;
    } ssnf_stat_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h3f;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5b;
            4'd3: s = 8'h4f;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6d;
            4'd6: s = 8'h7d;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/ssnf_ctrl.sv =====
// Sequencing state machine: accept, digit conversion, byte emission.
module ssnf_ctrl
    import ssnf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ssnf_stat_t stat,
    output ssnf_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (stat.is_clear || stat.conv_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/ssnf_dpath.sv =====
// Datapath: divide-by-ten digit extraction, digit store, byte select, output register.
module ssnf_dpath
    import ssnf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [VAL_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_wr_data,
    input  ssnf_cmd_t        cmd,
    output ssnf_stat_t       stat,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic [VAL_W-1:0] v_reg;
    logic             kind_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [3:0]       dig_reg [NUM_DIGITS];
    logic [2:0]       bright_reg;
    logic             valid_reg;
    logic [7:0]       data_reg;
    logic             user_reg;
    logic             last_reg;

    logic [63:0]      prod;
    logic [VAL_W-1:0] quot;
    logic [VAL_W-1:0] quot10;
    logic [3:0]       rem;
    logic             conv_done;

    logic [IDX_W-2:0] pos;
    logic [DIG_W-1:0] dsel;
    logic [7:0]       byte_d;
    logic             strobe_d;
    logic             last_d;

    assign prod = 64'(v_reg) * RECIP10;
    assign quot = VAL_W'(prod >> RECIP10_SHIFT);
    assign quot10 = (quot << 3) + (quot << 1);
    assign rem = 4'(v_reg - quot10);
    assign conv_done = (v_reg == '0) || (cnt_reg == CNT_W'(NUM_DIGITS));

    assign pos = idx_reg[IDX_W-1:1];
    assign dsel = DIG_W'(NUM_DIGITS - 1) - pos[DIG_W-1:0];

    always_comb begin
        byte_d = BYTE_ZERO;
        strobe_d = 1'b0;
        last_d = 1'b0;
        if (kind_reg == CMD_CLEAR) begin
            if (idx_reg == '0) begin
                byte_d = BYTE_AUTO_INC;
                strobe_d = 1'b1;
            end else if (idx_reg == IDX_W'(1)) begin
                byte_d = BYTE_ADDR0;
            end else if (idx_reg == CLEAR_LAST_IDX) begin
                byte_d = BYTE_DISP_ON | {5'b0, bright_reg};
                strobe_d = 1'b1;
                last_d = 1'b1;
            end else if (idx_reg == CLEAR_LAST_IDX - IDX_W'(1)) begin
                strobe_d = 1'b1;
            end
        end else begin
            if (idx_reg == '0) begin
                byte_d = BYTE_ADDR0;
            end else if (idx_reg[0]) begin
                // blank positions left of the highest digit
                if (IDX_W'(pos) + IDX_W'(cnt_reg) >= IDX_W'(NUM_DIGITS)) begin
                    byte_d = seg_code(dig_reg[dsel]);
                end
            end else if (idx_reg == SHOW_LAST_IDX) begin
                strobe_d = 1'b1;
                last_d = 1'b1;
            end
        end
    end

    assign stat.conv_done = conv_done;
    assign stat.is_clear = (kind_reg == CMD_CLEAR);
    assign stat.emit_last = last_d;
    assign stat.out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg <= s_tdata;
            kind_reg <= s_tuser;
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            if (cmd.step && !conv_done) begin
                dig_reg[cnt_reg[DIG_W-1:0]] <= rem;
                v_reg <= quot;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (cmd.emit) begin
            data_reg <= byte_d;
            user_reg <= strobe_d;
            last_reg <= last_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= 3'd1;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                bright_reg <= cfg_wr_data;
            end
            if (cmd.emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;
    assign m_tuser = user_reg;
    assign m_tlast = last_reg;

endmodule

// ===== hdl/seven_segment_number_frame_unit.sv =====
// Top level of the seven-segment display frame unit.
// Flow: a show word is accepted, converted to up to 8 digits (one divide-by-ten per
// cycle via reciprocal multiply) and handed off, then sent as 17 bytes; a clear word is
// accepted and handed off, then sent as 19 bytes. A new word is accepted only once the
// last frame byte is emitted; bytes leave at one per cycle from the output register when not stalled.
// Reset: aresetn low synchronously idles the sequencer, empties the output, brightness = 1.
module seven_segment_number_frame_unit
    import ssnf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [VAL_W-1:0] s_tdata,     // [31:0] value
    input  logic             s_tuser,     // [0] command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,     // [7:0] frame_byte
    output logic             m_tuser,     // [0] strobe_end
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_wr_data
);

    ssnf_cmd_t  cmd;
    ssnf_stat_t stat;

    ssnf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssnf_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_tready)
        else $error("byte emitted while accepting words");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("byte emitted into a full output register");

    a_accept_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted before frame done");

endmodule
